FILE: design/mpcg_pkg.sv
`default_nettype none

package mpcg_pkg;

  // Fixed field widths.
  localparam int IO_LANES    = 4;
  localparam int BASE_W      = 32;
  localparam int RATE_W      = 22;
  localparam int RATE_FRAC_W = 16;
  localparam int OFFSET_W    = 16;
  localparam int PHASE_OUT_W = 16;
  localparam int MV_W        = 15;
  localparam int PULSE_W     = 16;

  // Parameter defaults.
  localparam int LANES_DEF       = 4;
  localparam int PULSE_TICKS_DEF = 48;
  localparam int PHASE_BITS_DEF  = 32;

  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

  // Schmitt thresholds in millivolts.
  localparam logic signed [MV_W-1:0] RUN_LO  = MV_W'(0);
  localparam logic signed [MV_W-1:0] RUN_HI  = MV_W'(1000);
  localparam logic signed [MV_W-1:0] RST_LO  = MV_W'(0);
  localparam logic signed [MV_W-1:0] RST_HI  = MV_W'(1000);
  localparam logic signed [MV_W-1:0] SYNC_LO = MV_W'(100);
  localparam logic signed [MV_W-1:0] SYNC_HI = MV_W'(1000);

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = RATE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BASE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BASE = CFG_IDX_W'(IO_LANES);

  // Tick-wide control that every lane needs.
  typedef struct packed {
    logic rst_edge;
    logic run;
  } lane_ctrl_t;

  typedef struct packed {
    logic state;
    logic rise;
  } schmitt_t;

  function automatic schmitt_t schmitt_f(input logic st,
                                         input logic signed [MV_W-1:0] mv,
                                         input logic signed [MV_W-1:0] lo,
                                         input logic signed [MV_W-1:0] hi);
    schmitt_t r;
    r.state = st;
    r.rise  = 1'b0;
    if (st) begin
      if (mv <= lo) r.state = 1'b0;
    end else if (mv >= hi) begin
      r.state = 1'b1;
      r.rise  = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/mpcg_lane.sv
`default_nettype none

module mpcg_lane #(
  parameter int PULSE_TICKS = mpcg_pkg::PULSE_TICKS_DEF,
  parameter int PHASE_BITS  = mpcg_pkg::PHASE_BITS_DEF
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     rate_we_i,
  input  wire                                     offset_we_i,
  input  wire  [mpcg_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire                                     s1_load_i,
  input  wire                                     s2_load_i,
  input  mpcg_pkg::lane_ctrl_t                    s1_ctrl_i,
  input  mpcg_pkg::lane_ctrl_t                    s2_ctrl_i,
  input  wire  [mpcg_pkg::BASE_W-1:0]             base_step_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]        sync_mv_i,
  output logic [mpcg_pkg::PHASE_OUT_W-1:0]        phase_o,
  output logic                                    clock_o
);
  import mpcg_pkg::*;

  localparam int PROD_W = BASE_W + RATE_W;
  localparam int SHIFT  = BASE_W + RATE_FRAC_W - PHASE_BITS;
  localparam int INC_W  = PROD_W - SHIFT;
  localparam int SUM_W  = INC_W + 1;

  logic [RATE_W-1:0]     rate_q;
  logic [OFFSET_W-1:0]   offset_q;
  logic                  sync_high_q;
  logic [INC_W-1:0]      inc_q;
  logic                  sync_edge_q;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PULSE_W-1:0]    pulse_q, pulse_d;

  schmitt_t          sync_s;
  logic              sync_upd;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic              trig;
  logic [PULSE_W-1:0] cnt;

  assign sync_s   = schmitt_f(sync_high_q, sync_mv_i, SYNC_LO, SYNC_HI);
  // Sync state only moves on a running tick without a global reset edge.
  assign sync_upd = s1_load_i && !s1_ctrl_i.rst_edge && s1_ctrl_i.run;
  assign prod     = PROD_W'(base_step_i) * PROD_W'(rate_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_ONE;
      offset_q    <= '0;
      sync_high_q <= 1'b0;
    end else begin
      if (rate_we_i) rate_q <= cfg_data_i[RATE_W-1:0];
      if (offset_we_i) offset_q <= cfg_data_i[OFFSET_W-1:0];
      if (sync_upd) sync_high_q <= sync_s.state;
    end
  end

  // Stage one: registered step product and sync edge.
  always_ff @(posedge clk_i) begin
    if (s1_load_i) begin
      inc_q       <= prod[PROD_W-1:SHIFT];
      sync_edge_q <= sync_s.rise;
    end
  end

  // Stage two: accumulate, wrap and pulse.
  assign sum = SUM_W'(phase_q) + SUM_W'(inc_q);

  always_comb begin
    phase_d = phase_q;
    trig    = 1'b0;
    if (s2_ctrl_i.rst_edge) begin
      phase_d = '0;
      trig    = 1'b1;
    end else if (s2_ctrl_i.run) begin
      if (sync_edge_q) begin
        phase_d = '0;
        trig    = 1'b1;
      end else begin
        phase_d = sum[PHASE_BITS-1:0];
        trig    = |sum[SUM_W-1:PHASE_BITS];
      end
    end
    cnt     = trig ? PULSE_W'(PULSE_TICKS) : pulse_q;
    pulse_d = (cnt != '0) ? cnt - PULSE_W'(1) : cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pulse_q <= '0;
    end else if (s2_load_i) begin
      phase_q <= phase_d;
      pulse_q <= pulse_d;
    end
  end

  assign clock_o = |pulse_d;
  assign phase_o = phase_d[PHASE_BITS-1 -: PHASE_OUT_W] + offset_q;

endmodule

`default_nettype wire

FILE: design/mpcg_merge.sv
`default_nettype none

module mpcg_merge #(
  parameter int LANES = mpcg_pkg::LANES_DEF
) (
  input  wire                                clk_i,
  input  wire                                load_i,
  input  wire  [mpcg_pkg::PHASE_OUT_W-1:0]   lane_phase_i [LANES],
  input  wire                                lane_clock_i [LANES],
  output logic [mpcg_pkg::PHASE_OUT_W-1:0]   phase_o [mpcg_pkg::IO_LANES],
  output logic                               clock_o [mpcg_pkg::IO_LANES]
);
  import mpcg_pkg::*;

  logic [PHASE_OUT_W-1:0] phase_d [IO_LANES];
  logic                   clock_d [IO_LANES];

  // Lanes beyond the output count are dropped; missing lanes read as zero.
  for (genvar i = 0; i < IO_LANES; i++) begin : g_sel
    if (i < LANES) begin : g_used
      assign phase_d[i] = lane_phase_i[i];
      assign clock_d[i] = lane_clock_i[i];
    end else begin : g_unused
      assign phase_d[i] = '0;
      assign clock_d[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      phase_o <= phase_d;
      clock_o <= clock_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/multi_phasor_clock_generator_core.sv
`default_nettype none

// Multi-lane phase accumulator clock generator. Each accepted input item is one
// sample tick: with run high, each lane adds base step times its own rate to its
// phase, wraps at full scale and starts a clock pulse, high for PULSE_TICKS-1
// ticks, on a wrap or a rising sync edge; a rising reset edge clears all phases
// and starts pulses even with run low. One item is taken per clock unless the
// output stalls; while a result is stalled, one more can be taken before the
// input stalls. The transfer edge registers each lane's 32x22 step product, and
// the stage-two load closes the accumulator loop and loads the output register.
// The user must write rate (indices 0..3) and offset (4..7) registers via the
// configuration port only while idle (not enforced); other indices are ignored.
module multi_phasor_clock_generator_core #(
  parameter int LANES       = mpcg_pkg::LANES_DEF,
  parameter int PULSE_TICKS = mpcg_pkg::PULSE_TICKS_DEF,
  parameter int PHASE_BITS  = mpcg_pkg::PHASE_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Configuration write channel.
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [mpcg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [mpcg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel.
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [mpcg_pkg::BASE_W-1:0]         base_step_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]    run_mv_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]    reset_mv_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]    sync0_mv_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]    sync1_mv_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]    sync2_mv_i,
  input  wire  signed [mpcg_pkg::MV_W-1:0]    sync3_mv_i,
  // Output channel.
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [mpcg_pkg::PHASE_OUT_W-1:0]    phase_out0_o,
  output logic [mpcg_pkg::PHASE_OUT_W-1:0]    phase_out1_o,
  output logic [mpcg_pkg::PHASE_OUT_W-1:0]    phase_out2_o,
  output logic [mpcg_pkg::PHASE_OUT_W-1:0]    phase_out3_o,
  output logic                                clock_out0_o,
  output logic                                clock_out1_o,
  output logic                                clock_out2_o,
  output logic                                clock_out3_o
);
  import mpcg_pkg::*;

  logic run_high_q, reset_high_q;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  lane_ctrl_t s1_ctrl, s2_ctrl_q;
  schmitt_t run_s, rst_s;
  logic in_xfer, out_adv, s2_load;

  logic signed [MV_W-1:0] sync_in [IO_LANES];
  logic signed [MV_W-1:0] lane_sync [LANES];
  logic [PHASE_OUT_W-1:0] lane_phase [LANES];
  logic                   lane_clock [LANES];
  logic [PHASE_OUT_W-1:0] merged_phase [IO_LANES];
  logic                   merged_clock [IO_LANES];

  assign cfg_ready_o = 1'b1;

  // Pipeline flow: the output register frees up when empty or taken.
  assign out_adv     = !out_valid_q || !out_stall_i;
  assign s2_load     = s1_valid_q && out_adv;
  assign in_stall_o  = s1_valid_q && !out_adv;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_xfer || (s1_valid_q && !out_adv);
  assign out_valid_d = s2_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  assign run_s = schmitt_f(run_high_q, run_mv_i, RUN_LO, RUN_HI);
  assign rst_s = schmitt_f(reset_high_q, reset_mv_i, RST_LO, RST_HI);
  assign s1_ctrl.rst_edge = rst_s.rise;
  assign s1_ctrl.run      = run_s.state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_high_q   <= 1'b0;
      reset_high_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      s2_ctrl_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        run_high_q   <= run_s.state;
        reset_high_q <= rst_s.state;
        s2_ctrl_q    <= s1_ctrl;
      end
    end
  end

  assign sync_in[0] = sync0_mv_i;
  assign sync_in[1] = sync1_mv_i;
  assign sync_in[2] = sync2_mv_i;
  assign sync_in[3] = sync3_mv_i;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic rate_we, offset_we;

    // Lanes past the register set keep their reset rate and offset and
    // see a low sync level.
    if (i < IO_LANES) begin : g_io
      assign lane_sync[i] = sync_in[i];
      assign rate_we   = cfg_valid_i && cfg_ready_o &&
                         (cfg_index_i == CFG_RATE_BASE + CFG_IDX_W'(i));
      assign offset_we = cfg_valid_i && cfg_ready_o &&
                         (cfg_index_i == CFG_OFFSET_BASE + CFG_IDX_W'(i));
    end else begin : g_extra
      assign lane_sync[i] = '0;
      assign rate_we   = 1'b0;
      assign offset_we = 1'b0;
    end

    mpcg_lane #(
      .PULSE_TICKS (PULSE_TICKS),
      .PHASE_BITS  (PHASE_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rate_we_i   (rate_we),
      .offset_we_i (offset_we),
      .cfg_data_i  (cfg_data_i),
      .s1_load_i   (in_xfer),
      .s2_load_i   (s2_load),
      .s1_ctrl_i   (s1_ctrl),
      .s2_ctrl_i   (s2_ctrl_q),
      .base_step_i (base_step_i),
      .sync_mv_i   (lane_sync[i]),
      .phase_o     (lane_phase[i]),
      .clock_o     (lane_clock[i])
    );
  end

  mpcg_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i        (clk_i),
    .load_i       (s2_load),
    .lane_phase_i (lane_phase),
    .lane_clock_i (lane_clock),
    .phase_o      (merged_phase),
    .clock_o      (merged_clock)
  );

  assign phase_out0_o = merged_phase[0];
  assign phase_out1_o = merged_phase[1];
  assign phase_out2_o = merged_phase[2];
  assign phase_out3_o = merged_phase[3];
  assign clock_out0_o = merged_clock[0];
  assign clock_out1_o = merged_clock[1];
  assign clock_out2_o = merged_clock[2];
  assign clock_out3_o = merged_clock[3];

endmodule

`default_nettype wire

FILE: tb/sv/mpcg_tick_monitor.sv
`timescale 1ns / 1ps

module mpcg_tick_monitor
  import mpcg_pkg::*;
#(
  parameter int LANES       = LANES_DEF,
  parameter int PULSE_TICKS = PULSE_TICKS_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [BASE_W-1:0]            base_step_i,
  input  logic signed [MV_W-1:0]       run_mv_i,
  input  logic signed [MV_W-1:0]       reset_mv_i,
  input  logic signed [MV_W-1:0]       sync0_mv_i,
  input  logic signed [MV_W-1:0]       sync1_mv_i,
  input  logic signed [MV_W-1:0]       sync2_mv_i,
  input  logic signed [MV_W-1:0]       sync3_mv_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [PHASE_OUT_W-1:0]       phase_out0_i,
  input  logic [PHASE_OUT_W-1:0]       phase_out1_i,
  input  logic [PHASE_OUT_W-1:0]       phase_out2_i,
  input  logic [PHASE_OUT_W-1:0]       phase_out3_i,
  input  logic                         clock_out0_i,
  input  logic                         clock_out1_i,
  input  logic                         clock_out2_i,
  input  logic                         clock_out3_i,
  output int                           errors_o,
  output int                           outstanding_o
);

  typedef struct packed {
    logic [IO_LANES-1:0][PHASE_OUT_W-1:0] phase;
    logic [IO_LANES-1:0]                  clock;
  } lane_levels_t;

  logic [63:0]           lane_phase  [LANES];
  logic [PULSE_W-1:0]    pulse_left  [LANES];
  logic                  sync_high   [LANES];
  logic                  run_high;
  logic                  reset_high;
  logic [RATE_W-1:0]     lane_rate   [LANES];
  logic [OFFSET_W-1:0]   lane_offset [LANES];

  lane_levels_t          expected_levels[$];
  int                    error_count = 0;
  int                    outstanding = 0;
  int                    tick_count  = 0;

  logic [IO_LANES-1:0][PHASE_OUT_W-1:0] got_phase;
  logic [IO_LANES-1:0]                  got_clock;

  assign got_phase     = {phase_out3_i, phase_out2_i, phase_out1_i, phase_out0_i};
  assign got_clock     = {clock_out3_i, clock_out2_i, clock_out1_i, clock_out0_i};
  assign errors_o      = error_count;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Returns {new state, rising edge}.
  function automatic logic [1:0] schmitt_next(logic st, int mv, int lo, int hi);
    if (st) return {(mv > lo), 1'b0};
    if (mv >= hi) return 2'b11;
    return 2'b00;
  endfunction

  task automatic clear_lanes();
    for (int i = 0; i < LANES; i++) begin
      lane_phase[i]  = '0;
      pulse_left[i]  = '0;
      sync_high[i]   = 1'b0;
      lane_rate[i]   = RATE_ONE;
      lane_offset[i] = '0;
    end
    run_high   = 1'b0;
    reset_high = 1'b0;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int k;
    k = int'(idx);
    if (k < IO_LANES) begin
      if (k < LANES) lane_rate[k] = data[RATE_W-1:0];
    end else if (k < 2 * IO_LANES) begin
      if (k - IO_LANES < LANES) lane_offset[k - IO_LANES] = data[OFFSET_W-1:0];
    end
  endtask

  function automatic lane_levels_t advance_lanes(logic [BASE_W-1:0] base,
                                                 logic signed [MV_W-1:0] run_mv,
                                                 logic signed [MV_W-1:0] reset_mv,
                                                 logic [IO_LANES-1:0][MV_W-1:0] sync_mv);
    logic [63:0]      one;
    logic [63:0]      inc;
    logic [63:0]      sum;
    logic [LANES-1:0] trig;
    logic [1:0]       s;
    logic             rst_edge;
    int               mv;
    lane_levels_t     r;
    one  = 64'd1 << PHASE_BITS;
    trig = '0;
    s = schmitt_next(run_high, int'(run_mv), int'(RUN_LO), int'(RUN_HI));
    run_high = s[1];
    s = schmitt_next(reset_high, int'(reset_mv), int'(RST_LO), int'(RST_HI));
    reset_high = s[1];
    rst_edge   = s[0];
    if (rst_edge) begin
      for (int i = 0; i < LANES; i++) begin
        lane_phase[i] = '0;
        trig[i]       = 1'b1;
      end
    end else if (run_high) begin
      for (int i = 0; i < LANES; i++) begin
        // Lanes without a sync input see a constant low level.
        mv = 0;
        if (i < IO_LANES) mv = int'($signed(sync_mv[i]));
        s = schmitt_next(sync_high[i], mv, int'(SYNC_LO), int'(SYNC_HI));
        sync_high[i] = s[1];
        if (s[0]) begin
          lane_phase[i] = '0;
          trig[i]       = 1'b1;
        end else begin
          inc = (64'(base) * 64'(lane_rate[i])) >> (48 - PHASE_BITS);
          sum = lane_phase[i] + inc;
          if (sum >= one) begin
            sum     = sum & (one - 64'd1);
            trig[i] = 1'b1;
          end
          lane_phase[i] = sum;
        end
      end
    end
    for (int i = 0; i < LANES; i++) begin
      if (trig[i]) pulse_left[i] = PULSE_W'(PULSE_TICKS);
      if (pulse_left[i] != '0) pulse_left[i] = pulse_left[i] - 1'b1;
    end
    r = '0;
    for (int i = 0; i < IO_LANES; i++) begin
      if (i < LANES) begin
        r.phase[i] = PHASE_OUT_W'(lane_phase[i] >> (PHASE_BITS - 16)) + lane_offset[i];
        r.clock[i] = (pulse_left[i] != '0);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lane_levels_t want;
    if (!rst_ni) begin
      clear_lanes();
      expected_levels.delete();
      outstanding <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", tick_count));
        end else begin
          want = expected_levels.pop_front();
          for (int i = 0; i < IO_LANES; i++) begin
            if (got_phase[i] !== want.phase[i])
              report_mismatch($sformatf("tick %0d: phase_out%0d is %h, expected %h",
                                        tick_count, i, got_phase[i], want.phase[i]));
            if (got_clock[i] !== want.clock[i])
              report_mismatch($sformatf("tick %0d: clock_out%0d is %b, expected %b",
                                        tick_count, i, got_clock[i], want.clock[i]));
          end
        end
        tick_count++;
      end
      if (in_valid_i && !in_stall_i)
        expected_levels.push_back(advance_lanes(base_step_i, run_mv_i, reset_mv_i,
                                                {sync3_mv_i, sync2_mv_i, sync1_mv_i,
                                                 sync0_mv_i}));
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      outstanding <= expected_levels.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mpcg_pkg::*;

  localparam int LANES          = LANES_DEF;
  localparam int PULSE_TICKS    = PULSE_TICKS_DEF;
  localparam int PHASE_BITS     = PHASE_BITS_DEF;
  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 8;
  localparam int TICKS_PER_PASS = 50;
  localparam int MAX_GAP        = 19;

  typedef struct packed {
    logic [BASE_W-1:0]                base;
    logic [MV_W-1:0]                  run_mv;
    logic [MV_W-1:0]                  reset_mv;
    logic [IO_LANES-1:0][MV_W-1:0]    sync_mv;
  } tick_t;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;
  logic                    in_valid    = 1'b0;
  logic [BASE_W-1:0]       base_step   = '0;
  logic signed [MV_W-1:0]  run_mv      = '0;
  logic signed [MV_W-1:0]  reset_mv    = '0;
  logic signed [MV_W-1:0]  sync_mv [IO_LANES] = '{default: '0};
  logic                    out_stall   = 1'b0;

  logic                    cfg_ready;
  logic                    in_stall;
  logic                    out_valid;
  logic [PHASE_OUT_W-1:0]  phase_out [IO_LANES];
  logic                    clock_out [IO_LANES];

  int                      errors;
  int                      outstanding;
  bit                      tx_quiet     = 1'b0;
  bit                      rx_quiet     = 1'b0;
  bit                      hold_request = 1'b0;

  always #4 clk = ~clk;

  multi_phasor_clock_generator_core #(
    .LANES       (LANES),
    .PULSE_TICKS (PULSE_TICKS),
    .PHASE_BITS  (PHASE_BITS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .base_step_i  (base_step),
    .run_mv_i     (run_mv),
    .reset_mv_i   (reset_mv),
    .sync0_mv_i   (sync_mv[0]),
    .sync1_mv_i   (sync_mv[1]),
    .sync2_mv_i   (sync_mv[2]),
    .sync3_mv_i   (sync_mv[3]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .phase_out0_o (phase_out[0]),
    .phase_out1_o (phase_out[1]),
    .phase_out2_o (phase_out[2]),
    .phase_out3_o (phase_out[3]),
    .clock_out0_o (clock_out[0]),
    .clock_out1_o (clock_out[1]),
    .clock_out2_o (clock_out[2]),
    .clock_out3_o (clock_out[3])
  );

  mpcg_tick_monitor #(
    .LANES       (LANES),
    .PULSE_TICKS (PULSE_TICKS),
    .PHASE_BITS  (PHASE_BITS)
  ) monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .base_step_i   (base_step),
    .run_mv_i      (run_mv),
    .reset_mv_i    (reset_mv),
    .sync0_mv_i    (sync_mv[0]),
    .sync1_mv_i    (sync_mv[1]),
    .sync2_mv_i    (sync_mv[2]),
    .sync3_mv_i    (sync_mv[3]),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .phase_out0_i  (phase_out[0]),
    .phase_out1_i  (phase_out[1]),
    .phase_out2_i  (phase_out[2]),
    .phase_out3_i  (phase_out[3]),
    .clock_out0_i  (clock_out[0]),
    .clock_out1_i  (clock_out[1]),
    .clock_out2_i  (clock_out[2]),
    .clock_out3_i  (clock_out[3]),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  function automatic tick_t mk_tick(logic [BASE_W-1:0] b, int run, int rst,
                                    int s0, int s1, int s2, int s3);
    tick_t t;
    t.base       = b;
    t.run_mv     = MV_W'(run);
    t.reset_mv   = MV_W'(rst);
    t.sync_mv[0] = MV_W'(s0);
    t.sync_mv[1] = MV_W'(s1);
    t.sync_mv[2] = MV_W'(s2);
    t.sync_mv[3] = MV_W'(s3);
    return t;
  endfunction

  // Level in mV: high at or above the upper threshold, a band around the
  // thresholds, or low down to the negative end of the field.
  function automatic logic [MV_W-1:0] draw_mv(int pct_high);
    int r;
    int v;
    r = int'($urandom_range(99, 0));
    if (r < pct_high)
      v = ($urandom_range(3, 0) == 0) ? 1000 : int'($urandom_range(16383, 1000));
    else if (r < pct_high + 10)
      v = int'($urandom_range(1100, 0));
    else
      v = -int'($urandom_range(16384, 0));
    return MV_W'(v);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    if ($urandom_range(99, 0) < 8) begin
      t.base     = $urandom;
      t.run_mv   = MV_W'($urandom);
      t.reset_mv = MV_W'($urandom);
      for (int i = 0; i < IO_LANES; i++) t.sync_mv[i] = MV_W'($urandom);
      return t;
    end
    case ($urandom_range(3, 0))
      0:       t.base = $urandom_range(32'h000F_FFFF, 0);
      1:       t.base = $urandom_range(32'h0FFF_FFFF, 0);
      2:       t.base = $urandom;
      default: t.base = $urandom >> $urandom_range(31, 0);
    endcase
    t.run_mv   = draw_mv(85);
    t.reset_mv = draw_mv(3);
    for (int i = 0; i < IO_LANES; i++) t.sync_mv[i] = draw_mv(12);
    return t;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_rate();
    case ($urandom_range(3, 0))
      0: return CFG_DATA_W'($urandom_range(2097152, 2048));
      1: begin
        case ($urandom_range(4, 0))
          0:       return '0;
          1:       return CFG_DATA_W'(2048);
          2:       return CFG_DATA_W'(RATE_ONE);
          3:       return CFG_DATA_W'(2097152);
          default: return '1;
        endcase
      end
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(131072, 32768));
    endcase
  endfunction

  // Upper data bits are random so the offset registers see them ignored.
  function automatic logic [CFG_DATA_W-1:0] draw_offset();
    if ($urandom_range(3, 0) == 0)
      return $urandom_range(1, 0) ? CFG_DATA_W'(65535) : '0;
    return CFG_DATA_W'($urandom);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_tick(tick_t t);
    int gap;
    gap = tx_quiet ? 0 : int'($urandom_range(MAX_GAP, 0));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    base_step <= t.base;
    run_mv    <= t.run_mv;
    reset_mv  <= t.reset_mv;
    for (int i = 0; i < IO_LANES; i++) sync_mv[i] <= t.sync_mv[i];
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every expected result has been transferred, then lets the
  // pipeline settle before the caller touches the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic configure_random();
    for (int r = 0; r < IO_LANES; r++)
      write_reg(CFG_IDX_W'(int'(CFG_RATE_BASE) + r), draw_rate());
    for (int r = 0; r < IO_LANES; r++)
      write_reg(CFG_IDX_W'(int'(CFG_OFFSET_BASE) + r), draw_offset());
    if ($urandom_range(1, 0) == 1)
      write_reg(CFG_IDX_W'($urandom_range(15, 2 * IO_LANES)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Result side: a random hold-off before each transfer, or one long stretch
  // on request so that the block backs up into its input.
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        n = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        n = rx_quiet ? 0 : int'($urandom_range(MAX_GAP, 0));
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    tick_t directed[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: run edges and the band, wraps, reset and sync edges.
    directed.push_back(mk_tick(32'h0000_0000, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'hFFFF_FFFF, 1000, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'h0000_0002, 999, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'h8000_0000, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'h8000_0000, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'h0001_0000, 16383, -16384, 99, 100, 101, -1));
    directed.push_back(mk_tick(32'h0001_0000, 16383, 999, 999, 999, 999, 999));
    directed.push_back(mk_tick(32'h0000_0000, 16383, 1000, 1000, 1000, 1000, 1000));
    directed.push_back(mk_tick(32'h0000_0000, 16383, 16383, 1000, 999, 16383, 1000));
    directed.push_back(mk_tick(32'h0001_E240, 16383, 1, 101, 1000, 500, 100));
    directed.push_back(mk_tick(32'h0001_E240, 16383, 0, 100, 100, -16384, 1000));
    // A reset edge takes effect even as run drops.
    directed.push_back(mk_tick(32'hFFFF_FFFF, -16384, 16383, 1000, 1000, 1000, 1000));
    directed.push_back(mk_tick(32'hFFFF_FFFF, -16384, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_tick(directed[i]);
    drain();

    // Extreme rates: frozen lane, largest raw value, smallest and top of range.
    write_reg(CFG_IDX_W'(int'(CFG_RATE_BASE) + 0), '0);
    write_reg(CFG_IDX_W'(int'(CFG_RATE_BASE) + 1), '1);
    write_reg(CFG_IDX_W'(int'(CFG_RATE_BASE) + 2), CFG_DATA_W'(2048));
    write_reg(CFG_IDX_W'(int'(CFG_RATE_BASE) + 3), CFG_DATA_W'(2097152));
    write_reg(CFG_IDX_W'(int'(CFG_OFFSET_BASE) + 0), '0);
    write_reg(CFG_IDX_W'(int'(CFG_OFFSET_BASE) + 1), CFG_DATA_W'(65535));
    write_reg(CFG_IDX_W'(int'(CFG_OFFSET_BASE) + 2), CFG_DATA_W'(1));
    write_reg(CFG_IDX_W'(int'(CFG_OFFSET_BASE) + 3), CFG_DATA_W'(32768));
    write_reg(CFG_IDX_W'(2 * IO_LANES), '1);
    write_reg('1, CFG_DATA_W'(22'h2A_AAAA));
    cfg_valid <= 1'b0;
    directed.delete();
    directed.push_back(mk_tick(32'hFFFF_FFFF, 1000, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'hFFFF_FFFF, 1000, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'h0000_0001, 1000, 0, 0, 0, 0, 0));
    directed.push_back(mk_tick(32'h1234_5678, 1000, 0, 1000, 1000, 1000, 1000));
    directed.push_back(mk_tick(32'h8765_4321, 1000, 0, 100, 100, 100, 100));
    directed.push_back(mk_tick(32'hFFFF_FFFF, 1000, 1000, 0, 0, 0, 0));
    foreach (directed[i]) send_tick(directed[i]);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // One pass without idling, one with a long result-side hold-off while
      // the input side keeps pushing.
      tx_quiet = (ph == 1) || (ph == 3);
      rx_quiet = (ph == 1);
      if (ph == 3) hold_request = 1'b1;
      configure_random();
      for (int n = 0; n < TICKS_PER_PASS; n++) send_tick(rand_tick());
      drain();
    end

    if (errors == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
